FILE: hw/rtl/pim_pkg.sv
// ----------------------------------------------------------------------------
// Strided range matcher package
// Shared constants, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pim_pkg;

	// Default table depth and step width.
	localparam int DEF_MAX_SLICES = 8;
	localparam int DEF_STEP_WIDTH = 31;

	// Width of the slices-in-use register and of the entry index field.
	localparam int CFG_W       = 4;
	localparam int ENTRY_IDX_W = 3;

	// Item kind carried on the input tuser.
	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} pim_op_t;

	// Query sequencer states.
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_READ   = 7'b0000010,
		ST_SETUP  = 7'b0000100,
		ST_DIVIDE = 7'b0001000,
		ST_BASE   = 7'b0010000,
		ST_FOLD   = 7'b0100000,
		ST_FINISH = 7'b1000000
	} pim_state_t;

endpackage

FILE: hw/rtl/periodic_interval_matcher_core.sv
// ----------------------------------------------------------------------------
// Periodic interval matcher core
// Table of strided ranges, answered one query at a time with a shared divider.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries words of two kinds, chosen by s_tuser. A write word
// loads one table entry (start, stop, period) and gives no output word. A query
// word asks about one step and gives exactly one output word with membership,
// next member, previous member, inclusive previous member, local period and
// the activated flag.
// The cfg channel writes the number of entries taking part in queries; it is
// always ready. The user must write it only while the core is idle; the core
// itself does not enforce this. A query walks the entries in use, clamped to
// MAX_SLICES, one after another. Each entry takes a table read and a setup
// step; when it needs a division it also runs the one-bit-per-cycle restoring
// remainder unit, then a base step and a fold step.
// s_tready is low while a query runs and returns high in the same cycle that
// the result becomes valid. The result sits in an output register; the next
// word is accepted while it waits. A query that finishes while the previous
// result is still stalled waits in its last state until the receiver takes
// that result.
// Reset clears the slice count, the sequencer and the output valid. Table
// entries hold no reset value and must be written before they are used.
// ----------------------------------------------------------------------------
module periodic_interval_matcher_core #(
	parameter int MAX_SLICES = pim_pkg::DEF_MAX_SLICES,
	parameter int STEP_WIDTH = pim_pkg::DEF_STEP_WIDTH
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [pim_pkg::CFG_W-1:0]                   cfg_data,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// entry_index, range_start, range_stop, range_period, step, zero fill
	input  logic [((3+4*STEP_WIDTH+7)/8)*8-1:0]         s_tdata,
	// operation
	input  logic                                        s_tuser,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// is_member, next_member, previous_member, previous_inclusive,
	// local_period, activated, zero fill
	output logic [((2+4*STEP_WIDTH+7)/8)*8-1:0]         m_tdata
);
	import pim_pkg::*;

	localparam int W          = STEP_WIDTH;
	localparam int IDX_W      = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int CNT_W      = $clog2(MAX_SLICES + 1);
	localparam int BIT_W      = $clog2(W + 1);
	localparam int OUT_DATA_W = ((2 + 4 * W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - (2 + 4 * W);

	// Input word fields.
	logic [ENTRY_IDX_W-1:0] in_idx;
	logic [W-1:0]           in_start;
	logic [W-1:0]           in_stop;
	logic [W-1:0]           in_period;
	logic [W-1:0]           in_step;
	logic                   s_acc;
	logic                   wr_en;

	assign in_idx    = s_tdata[ENTRY_IDX_W-1:0];
	assign in_start  = s_tdata[ENTRY_IDX_W +: W];
	assign in_stop   = s_tdata[ENTRY_IDX_W + W +: W];
	assign in_period = s_tdata[ENTRY_IDX_W + 2*W +: W];
	assign in_step   = s_tdata[ENTRY_IDX_W + 3*W +: W];

	// Control state.
	pim_state_t             state_q;
	logic [CFG_W-1:0]       slices_q;
	logic [CNT_W-1:0]       ent_q;
	logic [BIT_W-1:0]       bit_q;
	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;

	// Range table.
	logic [W-1:0] start_mem  [MAX_SLICES];
	logic [W-1:0] stop_mem   [MAX_SLICES];
	logic [W-1:0] period_mem [MAX_SLICES];
	logic [W-1:0] rd_start_q;
	logic [W-1:0] rd_stop_q;
	logic [W-1:0] rd_period_q;

	// Query datapath.
	logic [W-1:0] step_q;
	logic [W-1:0] dvd_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] base_q;
	logic [W-1:0] nx_q;
	logic [W-1:0] pv_q;
	logic         inside_q;
	logic         mem_q;
	logic         act_q;

	logic [CNT_W-1:0] used_cnt;
	logic             last_ent;
	logic             p_zero;
	logic             n_ge_s;
	logic             t_ge_s;
	logic             n_le_t;
	logic             need_div;
	logic [W:0]       trial;
	logic [W:0]       next_c;
	logic [W-1:0]     prev_c;
	logic [W-1:0]     pi_val;
	logic [W-1:0]     local_val;
	logic             out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign wr_en     = s_acc && (pim_op_t'(s_tuser) == OP_WRITE) &&
	                   (32'(in_idx) < MAX_SLICES);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	// Entries in use, clamped to the table depth.
	always_comb begin
		if (32'(slices_q) > MAX_SLICES) begin
			used_cnt = CNT_W'(MAX_SLICES);
		end else begin
			used_cnt = CNT_W'(slices_q);
		end
	end

	assign last_ent = ((ent_q + CNT_W'(1)) == used_cnt);

	// Per-entry classification of the step against the entry just read.
	assign p_zero   = (rd_period_q == '0);
	assign n_ge_s   = (step_q >= rd_start_q);
	assign t_ge_s   = (rd_stop_q >= rd_start_q);
	assign n_le_t   = (step_q <= rd_stop_q);
	assign need_div = !p_zero && n_ge_s && t_ge_s;

	// Restoring remainder step: shift in one dividend bit, subtract if it fits.
	assign trial = {rem_q, dvd_q[W-1]};

	// Candidate members once the remainder is known.
	assign next_c = {1'b0, base_q} + {1'b0, rd_period_q};
	always_comb begin
		if (!inside_q) begin
			prev_c = base_q;
		end else if (step_q == rd_start_q) begin
			prev_c = '0;
		end else if (rem_q != '0) begin
			prev_c = base_q;
		end else begin
			prev_c = base_q - rd_period_q;
		end
	end

	// Final result fields.
	assign pi_val    = mem_q ? step_q : pv_q;
	assign local_val = nx_q - pi_val;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slices_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			slices_q <= cfg_data;
		end
	end

	// Range table write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[IDX_W'(in_idx)]  <= in_start;
			stop_mem[IDX_W'(in_idx)]   <= in_stop;
			period_mem[IDX_W'(in_idx)] <= in_period;
		end
		if (state_q == ST_READ) begin
			rd_start_q  <= start_mem[ent_q[IDX_W-1:0]];
			rd_stop_q   <= stop_mem[ent_q[IDX_W-1:0]];
			rd_period_q <= period_mem[ent_q[IDX_W-1:0]];
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ent_q      <= '0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output word becomes valid as a query leaves and clears once taken.
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (pim_op_t'(s_tuser) == OP_QUERY)) begin
						ent_q   <= '0;
						state_q <= (used_cnt == '0) ? ST_FINISH : ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					if (need_div) begin
						bit_q   <= BIT_W'(W);
						state_q <= ST_DIVIDE;
					end else if (last_ent) begin
						state_q <= ST_FINISH;
					end else begin
						ent_q   <= ent_q + CNT_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_DIVIDE: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == BIT_W'(1)) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (last_ent) begin
						state_q <= ST_FINISH;
					end else begin
						ent_q   <= ent_q + CNT_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query datapath: divider, accumulators and the output word.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc && (pim_op_t'(s_tuser) == OP_QUERY)) begin
					step_q <= in_step;
					mem_q  <= 1'b0;
					act_q  <= 1'b0;
					nx_q   <= '1;
					pv_q   <= '0;
				end
			end
			ST_SETUP: begin
				if (!p_zero && t_ge_s) begin
					act_q <= 1'b1;
				end
				if (need_div) begin
					// Inside the range divide the offset of the step, past it the span.
					dvd_q    <= n_le_t ? (step_q - rd_start_q) : (rd_stop_q - rd_start_q);
					rem_q    <= '0;
					inside_q <= n_le_t;
				end else if (!p_zero && !n_ge_s && t_ge_s && (rd_start_q < nx_q)) begin
					// Step before the range: the start is the next member.
					nx_q <= rd_start_q;
				end
			end
			ST_DIVIDE: begin
				if (trial >= {1'b0, rd_period_q}) begin
					rem_q <= W'(trial - {1'b0, rd_period_q});
				end else begin
					rem_q <= trial[W-1:0];
				end
				dvd_q <= dvd_q << 1;
			end
			ST_BASE: begin
				// Member at or below the step (inside) or at or below the stop.
				base_q <= inside_q ? (step_q - rem_q) : (rd_stop_q - rem_q);
			end
			ST_FOLD: begin
				if (inside_q) begin
					if (rem_q == '0) begin
						mem_q <= 1'b1;
					end
					if ((next_c <= {1'b0, rd_stop_q}) && (next_c[W-1:0] < nx_q)) begin
						nx_q <= next_c[W-1:0];
					end
				end
				if (prev_c > pv_q) begin
					pv_q <= prev_c;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					m_tdata_q <= {{OUT_PAD_W{1'b0}}, act_q, local_val, pi_val, pv_q,
					              nx_q, mem_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/pim_checker.sv
// ----------------------------------------------------------------------------
// Periodic interval matcher port checker
// Watches the core's ports and checks handshake and result consistency.
// ----------------------------------------------------------------------------
module pim_checker #(
	parameter int STEP_WIDTH = pim_pkg::DEF_STEP_WIDTH
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((2+4*STEP_WIDTH+7)/8)*8-1:0] m_tdata
);
	import pim_pkg::*;

	localparam int W = STEP_WIDTH;

	logic         out_member;
	logic [W-1:0] out_next;
	logic [W-1:0] out_prev;
	logic [W-1:0] out_pi;
	logic [W-1:0] out_local;

	assign out_member = m_tdata[0];
	assign out_next   = m_tdata[1 +: W];
	assign out_prev   = m_tdata[1 + W +: W];
	assign out_pi     = m_tdata[1 + 2*W +: W];
	assign out_local  = m_tdata[1 + 3*W +: W];

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// The core is ready again in the cycle after a table write is taken.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_WRITE) |=> s_tready)
		else $error("core busy after a table write");

	// A query keeps the core busy.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
		else $error("core ready right after a query");

	// Result fields agree with each other.
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_local == W'(out_next - out_pi)) &&
		             (out_member || (out_pi == out_prev)))
		else $error("inconsistent result word");

endmodule

bind periodic_interval_matcher_core pim_checker #(
	.STEP_WIDTH(STEP_WIDTH)
) u_pim_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
